>>> design/scc_pkg.sv
// Package with types, register indexes and coefficient tables of the speech compressor chain.
`default_nettype none

package scc_pkg;

    // Fixed widths of the data path.
    localparam int SAMPLE_W = 16;
    localparam int COEF_W   = 24;
    localparam int SIG_W    = 32;
    localparam int NUM_BW   = 5;

    typedef logic signed [SAMPLE_W-1:0] sample_t;
    typedef logic signed [COEF_W-1:0]   coef_t;
    typedef logic signed [SIG_W-1:0]    sig_t;
    typedef logic signed [47:0]         wide_t;
    typedef logic signed [32:0]         opa_t;
    typedef logic signed [31:0]         opb_t;
    typedef logic signed [64:0]         prod_t;
    typedef logic signed [36:0]         tg_t;

    // Configuration register indexes.
    localparam logic [2:0] REG_AGC_TARGET   = 3'd0;
    localparam logic [2:0] REG_AGC_MAX_GAIN = 3'd1;
    localparam logic [2:0] REG_CLIP_LEVEL   = 3'd2;
    localparam logic [2:0] REG_PREEMPHASIS  = 3'd3;
    localparam logic [2:0] REG_BANDWIDTH    = 3'd4;
    localparam logic [2:0] REG_RATE         = 3'd5;

    // Scaling of decimal constants given in units of 1e-7.
    localparam longint QDen   = 64'sd10000000;
    localparam longint QHalf  = 64'sd5000000;
    localparam longint CScale = 64'sd4194304;
    localparam longint SScale = 64'sd67108864;

    // Coefficient in Q2.22, rounded to nearest, ties away from zero.
    function automatic coef_t qc(input longint n);
        longint r;
        r = (n * CScale + ((n < 0) ? -QHalf : QHalf)) / QDen;
        return coef_t'(r);
    endfunction

    // Signal level in Q6.26, rounded half up.
    function automatic sig_t qs(input longint n);
        longint r;
        r = (n * SScale + QHalf) / QDen;
        return sig_t'(r);
    endfunction

    // Highpass biquad per rate: b0, b1, b2, a1, a2.
    localparam coef_t HP_TAB [2][5] = '{
        '{qc(9186000), qc(-18372000), qc(9186000), qc(-18347000), qc(8408000)},
        '{qc(9592000), qc(-19183000), qc(9592000), qc(-19166000), qc(9201000)}
    };

    // Lowpass biquad per rate and bandwidth: b0, b1, b2, a1, a2.
    localparam coef_t LP_TAB [2][5][5] = '{
        '{'{qc(976311),  qc(1952621), qc(976311),  qc(-9428090), qc(3333333)},
          '{qc(1139867), qc(2279734), qc(1139867), qc(-8447071), qc(3006538)},
          '{qc(1311064), qc(2622129), qc(1311064), qc(-7477892), qc(2722149)},
          '{qc(1568000), qc(3136000), qc(1568000), qc(-6102000), qc(2374000)},
          '{qc(1866943), qc(3733887), qc(1866943), qc(-4629380), qc(2097154)}},
        '{'{qc(299546),  qc(599092),  qc(299546),  qc(-14542436), qc(5740619)},
          '{qc(354376),  qc(708751),  qc(354376),  qc(-14014154), qc(5431657)},
          '{qc(412535),  qc(825071),  qc(412535),  qc(-13489677), qc(5139819)},
          '{qc(506000),  qc(1012000), qc(506000),  qc(-12711000), qc(4733000)},
          '{qc(604985),  qc(1209970), qc(604985),  qc(-11939134), qc(4359074)}}
    };

    // DC blocker, envelope attack and release per rate.
    localparam coef_t DC_A  [2] = '{qc(9990000), qc(9995000)};
    localparam coef_t DC_B  [2] = '{qc(10000),   qc(5000)};
    localparam coef_t ATK   [2] = '{qc(9400000), qc(9700000)};
    localparam coef_t REL   [2] = '{qc(9998000), qc(9999000)};
    localparam coef_t ATK_C [2] = '{qc(600000),  qc(300000)};
    localparam coef_t REL_C [2] = '{qc(2000),    qc(1000)};

    // Gain smoothing weights.
    localparam coef_t C_SMOOTH = qc(9500000);
    localparam coef_t C_TGW    = qc(500000);

    // Envelope floor for the gain update, gain floor and unity gain.
    localparam sig_t ENV_FLOOR  = qs(50000);
    localparam sig_t GAIN_FLOOR = qs(1000000);
    localparam sig_t GAIN_ONE   = sig_t'(SScale);

    // Fade-in length per rate.
    localparam logic [8:0] FADE_LEN [2] = '{9'd160, 9'd320};

    localparam wide_t SIG_MAX = wide_t'(32'sh7FFFFFFF);
    localparam wide_t SIG_MIN = -SIG_MAX - 48'sd1;

    // Saturate a wide sum to the signal width.
    function automatic sig_t sat_sig(input wide_t v);
        sig_t r;
        if (v > SIG_MAX)
            r = sig_t'(SIG_MAX);
        else if (v < SIG_MIN)
            r = sig_t'(SIG_MIN);
        else
            r = sig_t'(v);
        return r;
    endfunction

    // Symmetric clip against a non-negative limit.
    function automatic sig_t clip_sig(input wide_t v, input sig_t lim);
        sig_t r;
        if (v > wide_t'(lim))
            r = lim;
        else if (v < -wide_t'(lim))
            r = -lim;
        else
            r = sig_t'(v);
        return r;
    endfunction

endpackage

`default_nettype wire

>>> design/scc_if.sv
// Stream interfaces for the input and result words of the speech compressor chain.
`default_nettype none

interface scc_in_if import scc_pkg::*;;
    logic    valid;
    logic    ready;
    logic    command;
    sample_t sample_in;

    modport source (output valid, output command, output sample_in, input ready);
    modport sink (input valid, input command, input sample_in, output ready);
endinterface

interface scc_out_if import scc_pkg::*;;
    logic    valid;
    logic    ready;
    sample_t sample_out;

    modport source (output valid, output sample_out, input ready);
    modport sink (input valid, input sample_out, output ready);
endinterface

`default_nettype wire

>>> design/speech_compressor_chain_unit.sv
// Speech compressor chain: DC blocker, pre-emphasis, biquads, AGC, clip and fade-in.
//
// One sample word runs through a small sequencer that drives a single shared 33x32
// multiplier and a shared radix-2 restoring divider. The gain divide runs only when the
// envelope is above its floor, and the output divide is skipped with a zero clip level.
// The 35-bit gain quotient and the 17-bit output quotient come one bit per cycle from
// the divider, and the filter stages run one multiply per cycle. The input is ready
// only while the sequencer is idle; a finished word waits in the output register while
// the next word is taken, and a stalled output register holds the sequencer in its
// last state. A retrigger word only restarts the fade-in, gives no result and leaves
// the sequencer idle. Writing the bandwidth or rate register clears all filter,
// envelope, gain and fade state at once; configuration is to be written only while
// idle, which the block itself does not enforce.
`default_nettype none

module speech_compressor_chain_unit import scc_pkg::*; (
    input  wire logic        clk,
    input  wire logic        rst_n,
    scc_in_if.sink           in_ch,
    scc_out_if.source        out_ch,
    input  wire logic        cfg_we,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [15:0] cfg_data
);

    // Sequencer states.
    localparam logic [4:0] ST_IDLE   = 5'd0;
    localparam logic [4:0] ST_DC0    = 5'd1;
    localparam logic [4:0] ST_DC1    = 5'd2;
    localparam logic [4:0] ST_DC2    = 5'd3;
    localparam logic [4:0] ST_DC3    = 5'd4;
    localparam logic [4:0] ST_BQ     = 5'd5;
    localparam logic [4:0] ST_ENV0   = 5'd6;
    localparam logic [4:0] ST_ENV1   = 5'd7;
    localparam logic [4:0] ST_ENV2   = 5'd8;
    localparam logic [4:0] ST_TGSEL  = 5'd9;
    localparam logic [4:0] ST_DIV    = 5'd10;
    localparam logic [4:0] ST_DIVEND = 5'd11;
    localparam logic [4:0] ST_GN0    = 5'd12;
    localparam logic [4:0] ST_GN1    = 5'd13;
    localparam logic [4:0] ST_GN2    = 5'd14;
    localparam logic [4:0] ST_GN3    = 5'd15;
    localparam logic [4:0] ST_GN4    = 5'd16;
    localparam logic [4:0] ST_GN5    = 5'd17;
    localparam logic [4:0] ST_CLIP   = 5'd18;
    localparam logic [4:0] ST_FD0    = 5'd19;
    localparam logic [4:0] ST_FD1    = 5'd20;
    localparam logic [4:0] ST_DONE   = 5'd21;

    // Control registers.
    logic [4:0]  state_reg, state_next;
    logic [1:0]  bq_reg, bq_next;
    logic [2:0]  sub_reg, sub_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic        kind_reg, kind_next;
    logic        neg_reg, neg_next;
    logic        out_valid_reg, out_valid_next;

    // Configuration registers.
    logic [14:0] target_reg, target_next;
    logic [15:0] maxg_reg, maxg_next;
    logic [14:0] clip_reg, clip_next;
    logic [14:0] pre_reg, pre_next;
    logic [2:0]  bw_reg, bw_next;
    logic        rate_reg, rate_next;

    // Filter, envelope, gain and fade state.
    sig_t        dct_reg, dct_next;
    sig_t        prev_reg, prev_next;
    sig_t        hp1d0_reg, hp1d0_next, hp1d1_reg, hp1d1_next;
    sig_t        lp1d0_reg, lp1d0_next, lp1d1_reg, lp1d1_next;
    sig_t        hp2d0_reg, hp2d0_next, hp2d1_reg, hp2d1_next;
    sig_t        lp2d0_reg, lp2d0_next, lp2d1_reg, lp2d1_next;
    sig_t        env_reg, env_next;
    sig_t        gain_reg, gain_next;
    logic [8:0]  fade_reg, fade_next;

    // Working registers.
    sig_t        x_reg, x_next;
    sig_t        dco_reg, dco_next;
    sig_t        bx_reg, bx_next;
    sig_t        by_reg, by_next;
    wide_t       acc_reg, acc_next;
    prod_t       prod_reg, prod_next;
    tg_t         tg_reg, tg_next;
    logic [34:0] rem_reg, rem_next;
    logic [34:0] dq_reg, dq_next;
    logic [34:0] den_reg, den_next;
    sample_t     q_reg, q_next;
    sample_t     out_data_reg, out_data_next;

    // Shared multiplier operands.
    opa_t        mul_a;
    opb_t        mul_b;

    // Derived values.
    logic [2:0]  bwc;
    logic [2:0]  k_idx;
    coef_t       bq_coef;
    sig_t        d0_cur, d1_cur;
    wide_t       mr22, mr26, mr15;
    opa_t        mag;
    logic        attack;
    sig_t        lim;
    logic [25:0] lim26;
    logic        fading;
    logic [35:0] div_t36;
    logic        div_ge;
    logic [35:0] prod36;
    logic [34:0] pmag;
    logic [34:0] den_f;
    logic [50:0] dividend;
    logic [16:0] q17;
    tg_t         maxg37, tg_lo;
    logic        clear_all;
    sig_t        d0_new, d1_new;
    logic        wr_d0, wr_d1;

    assign in_ch.ready       = (state_reg == ST_IDLE);
    assign out_ch.valid      = out_valid_reg;
    assign out_ch.sample_out = out_data_reg;

    // Table selection and rounding of the registered product.
    assign bwc    = (bw_reg >= 3'(NUM_BW)) ? 3'(NUM_BW - 1) : bw_reg;
    assign lim26  = {clip_reg, 11'b0};
    assign lim    = sig_t'({6'b0, lim26});
    assign fading = (fade_reg < FADE_LEN[rate_reg]);
    assign mr22   = wide_t'((prod_reg + 65'sd2097152) >>> 22);
    assign mr26   = wide_t'((prod_reg + 65'sd33554432) >>> 26);
    assign mr15   = wide_t'((prod_reg + 65'sd16384) >>> 15);
    assign mag    = bx_reg[31] ? -opa_t'(bx_reg) : opa_t'(bx_reg);
    assign attack = (mag > opa_t'(env_reg));
    assign maxg37 = tg_t'({5'b0, maxg_reg, 14'b0});

    // Coefficient order within one biquad pass.
    always_comb
    begin
        unique case (sub_reg)
            3'd0:    k_idx = 3'd0;
            3'd1:    k_idx = 3'd1;
            3'd2:    k_idx = 3'd3;
            3'd3:    k_idx = 3'd2;
            3'd4:    k_idx = 3'd4;
            default: k_idx = 3'd0;
        endcase
        bq_coef = bq_reg[0] ? LP_TAB[rate_reg][bwc][k_idx] : HP_TAB[rate_reg][k_idx];
    end

    // Delay pair of the active biquad.
    always_comb
    begin
        unique case (bq_reg)
            2'd0:    begin d0_cur = hp1d0_reg; d1_cur = hp1d1_reg; end
            2'd1:    begin d0_cur = lp1d0_reg; d1_cur = lp1d1_reg; end
            2'd2:    begin d0_cur = hp2d0_reg; d1_cur = hp2d1_reg; end
            default: begin d0_cur = lp2d0_reg; d1_cur = lp2d1_reg; end
        endcase
    end

    // Divider step, output quotient and output divide setup.
    assign div_t36  = {rem_reg, dq_reg[34]};
    assign div_ge   = (div_t36 >= {1'b0, den_reg});
    assign prod36   = prod_reg[35:0];
    assign pmag     = prod36[35] ? 35'(-prod36) : prod36[34:0];
    assign q17      = dq_reg[16:0];
    assign dividend = {1'b0, pmag, 15'b0} + 51'(den_f >> 1);

    always_comb
    begin
        if (!fading)
            den_f = 35'(lim26);
        else if (rate_reg)
            den_f = 35'({lim26, 8'b0}) + 35'({lim26, 6'b0});
        else
            den_f = 35'({lim26, 7'b0}) + 35'({lim26, 5'b0});
    end

    // Gain target clamp: ceiling first, then floor.
    always_comb
    begin
        tg_lo = (tg_reg > maxg37) ? maxg37 : tg_reg;
        if (tg_lo < tg_t'(GAIN_FLOOR))
            tg_lo = tg_t'(GAIN_FLOOR);
    end

    // Sequencer.
    always_comb
    begin
        state_next     = state_reg;
        bq_next        = bq_reg;
        sub_next       = sub_reg;
        cnt_next       = cnt_reg;
        kind_next      = kind_reg;
        neg_next       = neg_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        target_next    = target_reg;
        maxg_next      = maxg_reg;
        clip_next      = clip_reg;
        pre_next       = pre_reg;
        bw_next        = bw_reg;
        rate_next      = rate_reg;
        dct_next       = dct_reg;
        prev_next      = prev_reg;
        hp1d0_next     = hp1d0_reg;
        hp1d1_next     = hp1d1_reg;
        lp1d0_next     = lp1d0_reg;
        lp1d1_next     = lp1d1_reg;
        hp2d0_next     = hp2d0_reg;
        hp2d1_next     = hp2d1_reg;
        lp2d0_next     = lp2d0_reg;
        lp2d1_next     = lp2d1_reg;
        env_next       = env_reg;
        gain_next      = gain_reg;
        fade_next      = fade_reg;
        x_next         = x_reg;
        dco_next       = dco_reg;
        bx_next        = bx_reg;
        by_next        = by_reg;
        acc_next       = acc_reg;
        tg_next        = tg_reg;
        rem_next       = rem_reg;
        dq_next        = dq_reg;
        den_next       = den_reg;
        q_next         = q_reg;
        mul_a          = '0;
        mul_b          = '0;
        clear_all      = 1'b0;
        d0_new         = d0_cur;
        d1_new         = d1_cur;
        wr_d0          = 1'b0;
        wr_d1          = 1'b0;

        if (out_valid_reg && out_ch.ready)
            out_valid_next = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_ch.valid)
                begin
                    if (in_ch.command)
                        fade_next = '0;
                    else
                    begin
                        x_next     = sig_t'(in_ch.sample_in) <<< 11;
                        state_next = ST_DC0;
                    end
                end
            end
            ST_DC0:
            begin
                mul_a      = opa_t'(dct_reg);
                mul_b      = opb_t'(DC_A[rate_reg]);
                dco_next   = sat_sig(wide_t'(x_reg) - wide_t'(dct_reg));
                state_next = ST_DC1;
            end
            ST_DC1:
            begin
                mul_a      = opa_t'(x_reg);
                mul_b      = opb_t'(DC_B[rate_reg]);
                acc_next   = mr22;
                state_next = ST_DC2;
            end
            ST_DC2:
            begin
                mul_a      = opa_t'(dco_reg) - opa_t'(prev_reg);
                mul_b      = opb_t'({1'b0, pre_reg});
                dct_next   = sat_sig(acc_reg + mr22);
                state_next = ST_DC3;
            end
            ST_DC3:
            begin
                bx_next    = sat_sig(wide_t'(dco_reg) + mr15);
                prev_next  = dco_reg;
                bq_next    = 2'd0;
                sub_next   = 3'd0;
                state_next = ST_BQ;
            end
            ST_BQ:
            begin
                // One coefficient product per cycle, consumed from the product register in the next cycle.
                mul_b    = opb_t'(bq_coef);
                mul_a    = (sub_reg == 3'd2 || sub_reg == 3'd4) ? opa_t'(by_reg)
                                                                : opa_t'(bx_reg);
                sub_next = sub_reg + 3'd1;
                unique case (sub_reg)
                    3'd0: ;
                    3'd1: by_next = sat_sig(mr22 + wide_t'(d0_cur));
                    3'd2: acc_next = mr22;
                    3'd3:
                    begin
                        d0_new = sat_sig(acc_reg - mr22 + wide_t'(d1_cur));
                        wr_d0  = 1'b1;
                    end
                    3'd4: acc_next = mr22;
                    default:
                    begin
                        d1_new   = sat_sig(acc_reg - mr22);
                        wr_d1    = 1'b1;
                        bx_next  = by_reg;
                        sub_next = 3'd0;
                        bq_next  = bq_reg + 2'd1;
                        if (bq_reg == 2'd1)
                            state_next = ST_ENV0;
                        else if (bq_reg == 2'd3)
                            state_next = ST_CLIP;
                    end
                endcase
            end
            ST_ENV0:
            begin
                mul_a      = opa_t'(env_reg);
                mul_b      = opb_t'(attack ? ATK[rate_reg] : REL[rate_reg]);
                state_next = ST_ENV1;
            end
            ST_ENV1:
            begin
                mul_a      = mag;
                mul_b      = opb_t'(attack ? ATK_C[rate_reg] : REL_C[rate_reg]);
                acc_next   = mr22;
                state_next = ST_ENV2;
            end
            ST_ENV2:
            begin
                env_next   = sat_sig(acc_reg + mr22);
                state_next = ST_TGSEL;
            end
            ST_TGSEL:
            begin
                // Above the floor the target gain is agc_target over the envelope.
                if (env_reg > ENV_FLOOR)
                begin
                    rem_next   = 35'({target_reg, 2'b0});
                    dq_next    = '0;
                    den_next   = {3'b0, env_reg};
                    cnt_next   = 6'd35;
                    kind_next  = 1'b0;
                    state_next = ST_DIV;
                end
                else
                begin
                    tg_next    = tg_t'(gain_reg);
                    state_next = ST_GN0;
                end
            end
            ST_DIV:
            begin
                rem_next = div_ge ? 35'(div_t36 - {1'b0, den_reg}) : div_t36[34:0];
                dq_next  = {dq_reg[33:0], div_ge};
                cnt_next = cnt_reg - 6'd1;
                if (cnt_reg == 6'd1)
                    state_next = ST_DIVEND;
            end
            ST_DIVEND:
            begin
                if (kind_reg)
                begin
                    if (neg_reg)
                        q_next = -sample_t'(q17);
                    else if (q17 > 17'd32767)
                        q_next = sample_t'(16'sh7FFF);
                    else
                        q_next = sample_t'(q17[15:0]);
                    state_next = ST_DONE;
                end
                else
                begin
                    tg_next    = tg_t'({2'b0, dq_reg});
                    state_next = ST_GN0;
                end
            end
            ST_GN0:
            begin
                tg_next    = tg_lo;
                state_next = ST_GN1;
            end
            ST_GN1:
            begin
                mul_a      = opa_t'(gain_reg);
                mul_b      = opb_t'(C_SMOOTH);
                state_next = ST_GN2;
            end
            ST_GN2:
            begin
                mul_a      = opa_t'(tg_reg);
                mul_b      = opb_t'(C_TGW);
                acc_next   = mr22;
                state_next = ST_GN3;
            end
            ST_GN3:
            begin
                gain_next  = sat_sig(acc_reg + mr22);
                state_next = ST_GN4;
            end
            ST_GN4:
            begin
                mul_a      = opa_t'(bx_reg);
                mul_b      = opb_t'(gain_reg);
                state_next = ST_GN5;
            end
            ST_GN5:
            begin
                bx_next    = clip_sig(mr26, lim);
                bq_next    = 2'd2;
                sub_next   = 3'd0;
                state_next = ST_BQ;
            end
            ST_CLIP:
            begin
                bx_next    = clip_sig(wide_t'(bx_reg), lim);
                state_next = ST_FD0;
            end
            ST_FD0:
            begin
                mul_a      = opa_t'(bx_reg);
                mul_b      = fading ? opb_t'({1'b0, fade_reg}) : 32'sd1;
                state_next = ST_FD1;
            end
            ST_FD1:
            begin
                if (fading)
                    fade_next = fade_reg + 9'd1;
                if (clip_reg == '0)
                begin
                    q_next     = '0;
                    state_next = ST_DONE;
                end
                else
                begin
                    neg_next   = prod36[35];
                    rem_next   = 35'(dividend >> 17);
                    dq_next    = {dividend[16:0], 18'b0};
                    den_next   = den_f;
                    cnt_next   = 6'd17;
                    kind_next  = 1'b1;
                    state_next = ST_DIV;
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || out_ch.ready)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = q_reg;
                    state_next     = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase

        // Delay write-back of the active biquad.
        if (wr_d0 || wr_d1)
        begin
            unique case (bq_reg)
                2'd0:
                begin
                    if (wr_d0) hp1d0_next = d0_new;
                    if (wr_d1) hp1d1_next = d1_new;
                end
                2'd1:
                begin
                    if (wr_d0) lp1d0_next = d0_new;
                    if (wr_d1) lp1d1_next = d1_new;
                end
                2'd2:
                begin
                    if (wr_d0) hp2d0_next = d0_new;
                    if (wr_d1) hp2d1_next = d1_new;
                end
                default:
                begin
                    if (wr_d0) lp2d0_next = d0_new;
                    if (wr_d1) lp2d1_next = d1_new;
                end
            endcase
        end

        // Configuration writes; profile changes clear the processing state.
        if (cfg_we)
        begin
            unique case (cfg_index)
                REG_AGC_TARGET:   target_next = cfg_data[14:0];
                REG_AGC_MAX_GAIN: maxg_next   = cfg_data;
                REG_CLIP_LEVEL:   clip_next   = cfg_data[14:0];
                REG_PREEMPHASIS:  pre_next    = cfg_data[14:0];
                REG_BANDWIDTH:
                begin
                    bw_next   = cfg_data[2:0];
                    clear_all = 1'b1;
                end
                REG_RATE:
                begin
                    rate_next = cfg_data[0];
                    clear_all = 1'b1;
                end
                default: ;
            endcase
        end

        if (clear_all)
        begin
            dct_next   = '0;
            prev_next  = '0;
            hp1d0_next = '0;
            hp1d1_next = '0;
            lp1d0_next = '0;
            lp1d1_next = '0;
            hp2d0_next = '0;
            hp2d1_next = '0;
            lp2d0_next = '0;
            lp2d1_next = '0;
            env_next   = '0;
            gain_next  = GAIN_ONE;
            fade_next  = '0;
        end
    end

    // Shared multiplier with its product register.
    assign prod_next = prod_t'(mul_a) * prod_t'(mul_b);

    // Control, configuration and processing state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            bq_reg        <= '0;
            sub_reg       <= '0;
            cnt_reg       <= '0;
            kind_reg      <= 1'b0;
            neg_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
            target_reg    <= 15'd4915;
            maxg_reg      <= 16'd6144;
            clip_reg      <= 15'd13107;
            pre_reg       <= '0;
            bw_reg        <= 3'd3;
            rate_reg      <= 1'b0;
            dct_reg       <= '0;
            prev_reg      <= '0;
            hp1d0_reg     <= '0;
            hp1d1_reg     <= '0;
            lp1d0_reg     <= '0;
            lp1d1_reg     <= '0;
            hp2d0_reg     <= '0;
            hp2d1_reg     <= '0;
            lp2d0_reg     <= '0;
            lp2d1_reg     <= '0;
            env_reg       <= '0;
            gain_reg      <= GAIN_ONE;
            fade_reg      <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            bq_reg        <= bq_next;
            sub_reg       <= sub_next;
            cnt_reg       <= cnt_next;
            kind_reg      <= kind_next;
            neg_reg       <= neg_next;
            out_valid_reg <= out_valid_next;
            target_reg    <= target_next;
            maxg_reg      <= maxg_next;
            clip_reg      <= clip_next;
            pre_reg       <= pre_next;
            bw_reg        <= bw_next;
            rate_reg      <= rate_next;
            dct_reg       <= dct_next;
            prev_reg      <= prev_next;
            hp1d0_reg     <= hp1d0_next;
            hp1d1_reg     <= hp1d1_next;
            lp1d0_reg     <= lp1d0_next;
            lp1d1_reg     <= lp1d1_next;
            hp2d0_reg     <= hp2d0_next;
            hp2d1_reg     <= hp2d1_next;
            lp2d0_reg     <= lp2d0_next;
            lp2d1_reg     <= lp2d1_next;
            env_reg       <= env_next;
            gain_reg      <= gain_next;
            fade_reg      <= fade_next;
        end
    end

    // Working data path registers.
    always_ff @(posedge clk)
    begin
        x_reg        <= x_next;
        dco_reg      <= dco_next;
        bx_reg       <= bx_next;
        by_reg       <= by_next;
        acc_reg      <= acc_next;
        prod_reg     <= prod_next;
        tg_reg       <= tg_next;
        rem_reg      <= rem_next;
        dq_reg       <= dq_next;
        den_reg      <= den_next;
        q_reg        <= q_next;
        out_data_reg <= out_data_next;
    end

endmodule

`default_nettype wire

>>> design/scc_checker.sv
// Port-level checker of the speech compressor chain and its bind to the top level.
`default_nettype none

module scc_checker (
    input wire logic clk,
    input wire logic rst_n,
    input wire logic in_valid,
    input wire logic in_ready,
    input wire logic in_command,
    input wire logic out_valid,
    input wire logic out_ready
);

    // A sample word keeps the block busy for at least the next cycle.
    a_busy_after_sample: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && !in_command) |=> !in_ready)
        else $error("block ready right after taking a sample word");

    // A retrigger word leaves the block idle and makes no result.
    a_retrigger_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && in_command) |=> (in_ready && !$rose(out_valid)))
        else $error("retrigger word made a result or busied the block");

    // A result only appears after a busy cycle.
    a_result_after_work: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(!in_ready))
        else $error("result appeared without work");

    // A result word waits until taken.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> out_valid)
        else $error("result word dropped before taken");

endmodule

bind speech_compressor_chain_unit scc_checker u_scc_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_ch.valid),
    .in_ready   (in_ch.ready),
    .in_command (in_ch.command),
    .out_valid  (out_ch.valid),
    .out_ready  (out_ch.ready)
);

`default_nettype wire

>>> sim/speech_compressor_chain_unit_tb.sv
// Self-checking testbench for the speech compressor chain with a built-in bit-exact predictor.
`timescale 1ns / 100ps

module speech_compressor_chain_unit_tb;
    import scc_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int SETTLE_CYCLES  = 150;
    localparam logic CMD_SAMPLE  = 1'b0;
    localparam logic CMD_RESTART = 1'b1;

    typedef struct {
        logic    command;
        sample_t sample;
    } word_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [2:0]  cfg_index;
    logic [15:0] cfg_data;

    scc_in_if  in_ch ();
    scc_out_if out_ch ();

    speech_compressor_chain_unit u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .out_ch    (out_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    word_t   pending_words [$];
    sample_t expected_samples [$];
    int      error_count;
    int      idle_cycles;
    bit      no_idling;
    int      send_gap;
    int      recv_stall;

    // Shadow copy of the configuration and of the filter state.
    int      target_lvl, max_gain, clip_lvl, emph_weight, bw_sel, rate_sel;
    longint  dc_trk, prev_dc_free, env_lvl, gain_lvl;
    longint  delay_line [4][2];
    int      fade_pos;

    // Clock generation; every input starts at a known value.
    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = REG_AGC_TARGET;
        cfg_data = '0;
        in_ch.valid = 1'b0;
        in_ch.command = CMD_SAMPLE;
        in_ch.sample_in = '0;
        out_ch.ready = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic longint sat_to(input longint x, input int w);
        longint hi;
        hi = (64'sd1 <<< (w - 1)) - 1;
        if (x > hi)
            return hi;
        if (x < -hi - 1)
            return -hi - 1;
        return x;
    endfunction

    function automatic longint sig(input longint x);
        return sat_to(x, SIG_W);
    endfunction

    function automatic longint round_shift(input longint x, input int n);
        return (x + (64'sd1 <<< (n - 1))) >>> n;
    endfunction

    function automatic longint coef_mul(input longint s, input longint c);
        return round_shift(s * c, COEF_W - 2);
    endfunction

    function automatic longint clip_to(input longint x, input longint lim);
        if (x > lim)
            return lim;
        if (x < -lim)
            return -lim;
        return x;
    endfunction

    // One biquad section in transposed direct form II on delay line st.
    function automatic longint biquad(input longint x, input int st, input coef_t k [5]);
        longint y;
        y = sig(coef_mul(x, k[0]) + delay_line[st][0]);
        delay_line[st][0] = sig(coef_mul(x, k[1]) - coef_mul(y, k[3]) + delay_line[st][1]);
        delay_line[st][1] = sig(coef_mul(x, k[2]) - coef_mul(y, k[4]));
        return y;
    endfunction

    function automatic void clear_chain();
        dc_trk = 0;
        prev_dc_free = 0;
        env_lvl = 0;
        gain_lvl = longint'(GAIN_ONE);
        fade_pos = 0;
        for (int i = 0; i < 4; i++)
        begin
            delay_line[i][0] = 0;
            delay_line[i][1] = 0;
        end
    endfunction

    // Computes the processed sample for one sample word and advances the state.
    function automatic sample_t compress_sample(input sample_t s);
        coef_t  hp [5];
        coef_t  lp [5];
        longint x, dc_out, emph, s2, mag, tg, maxg, lim, v, num, den, q;
        int     flen;
        hp = HP_TAB[rate_sel];
        lp = LP_TAB[rate_sel][(bw_sel > 4) ? 4 : bw_sel];
        flen = int'(FADE_LEN[rate_sel]);

        x = sig(longint'(s) <<< 11);
        dc_out = sig(x - dc_trk);
        dc_trk = sig(coef_mul(dc_trk, DC_A[rate_sel]) + coef_mul(x, DC_B[rate_sel]));
        emph = sig(dc_out + round_shift(longint'(emph_weight) * (dc_out - prev_dc_free), 15));
        prev_dc_free = dc_out;
        s2 = biquad(biquad(emph, 0, hp), 1, lp);

        // Peak envelope with separate attack and release.
        mag = (s2 < 0) ? -s2 : s2;
        if (mag > env_lvl)
            env_lvl = sig(coef_mul(env_lvl, ATK[rate_sel]) + coef_mul(mag, ATK_C[rate_sel]));
        else
            env_lvl = sig(coef_mul(env_lvl, REL[rate_sel]) + coef_mul(mag, REL_C[rate_sel]));

        // Gain target, clamped, then smoothed.
        tg = gain_lvl;
        if (env_lvl > longint'(ENV_FLOOR) && env_lvl > 0)
            tg = (longint'(target_lvl) <<< 37) / env_lvl;
        maxg = longint'(max_gain) <<< 14;
        if (tg > maxg)
            tg = maxg;
        if (tg < longint'(GAIN_FLOOR))
            tg = longint'(GAIN_FLOOR);
        gain_lvl = sig(coef_mul(gain_lvl, C_SMOOTH) + coef_mul(tg, C_TGW));

        // Clip, second filter pair, re-clip.
        lim = longint'(clip_lvl) <<< 11;
        v = clip_to(round_shift(s2 * gain_lvl, 26), lim);
        v = biquad(biquad(v, 2, hp), 3, lp);
        v = clip_to(v, lim);

        // Normalize and apply the fade-in ramp.
        q = 0;
        if (lim > 0)
        begin
            num = v <<< 15;
            den = lim;
            if (fade_pos < flen)
            begin
                num = num * fade_pos;
                den = den * flen;
                fade_pos = (fade_pos + 1) & 511;
            end
            if (num < 0)
                q = -((-num + den / 2) / den);
            else
                q = (num + den / 2) / den;
            q = sat_to(q, SAMPLE_W);
        end
        else if (fade_pos < flen)
        begin
            fade_pos = (fade_pos + 1) & 511;
        end
        return sample_t'(q);
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_idling || r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Sender: presents pending words with random gaps and feeds the predictor.
    always @(posedge clk)
    begin
        logic  nxt_valid;
        word_t w;
        nxt_valid = in_ch.valid;
        if (rst_n)
        begin
            if (in_ch.valid && in_ch.ready)
            begin
                w = pending_words.pop_front();
                if (w.command == CMD_RESTART)
                    fade_pos = 0;
                else
                    expected_samples.push_back(compress_sample(w.sample));
                send_gap = pick_gap();
                nxt_valid = 1'b0;
            end
            if (!(in_ch.valid && !in_ch.ready))
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    nxt_valid = 1'b0;
                end
                else if (pending_words.size() > 0)
                begin
                    nxt_valid = 1'b1;
                    in_ch.command <= pending_words[0].command;
                    in_ch.sample_in <= pending_words[0].sample;
                end
                else
                begin
                    nxt_valid = 1'b0;
                end
            end
        end
        in_ch.valid <= nxt_valid;
    end

    // Receiver: random back-pressure and comparison against the oldest expectation.
    always @(posedge clk)
    begin
        sample_t exp_s;
        if (rst_n)
        begin
            if (out_ch.valid && out_ch.ready)
            begin
                if (expected_samples.size() == 0)
                begin
                    $display("%0t: unexpected word, actual sample_out %0d", $time,
                             out_ch.sample_out);
                    error_count++;
                end
                else
                begin
                    exp_s = expected_samples.pop_front();
                    if (out_ch.sample_out !== exp_s)
                    begin
                        $display("%0t: sample_out mismatch, expected %0d actual %0d",
                                 $time, exp_s, out_ch.sample_out);
                        error_count++;
                    end
                end
            end
            if (recv_stall > 0)
            begin
                recv_stall--;
                out_ch.ready <= 1'b0;
            end
            else
            begin
                out_ch.ready <= 1'b1;
                if ($urandom_range(0, 5) == 0)
                    recv_stall = pick_gap();
            end
        end
    end

    // Watchdog on cycles without any accepted word or configuration write.
    always @(posedge clk)
    begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || cfg_we)
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t: watchdog expired", $time);
            $display("speech_compressor_chain_unit_tb NOT OK");
            $finish;
        end
    end

    task automatic wait_drained();
        do
            @(posedge clk);
        while (pending_words.size() != 0 || in_ch.valid || expected_samples.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input int val);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val[15:0];
        case (idx)
            REG_AGC_TARGET:   target_lvl = val & 32'h7FFF;
            REG_AGC_MAX_GAIN: max_gain = val & 32'hFFFF;
            REG_CLIP_LEVEL:   clip_lvl = val & 32'h7FFF;
            REG_PREEMPHASIS:  emph_weight = val & 32'h7FFF;
            REG_BANDWIDTH:
            begin
                bw_sel = val & 7;
                clear_chain();
            end
            REG_RATE:
            begin
                rate_sel = val & 1;
                clear_chain();
            end
            default: ;
        endcase
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic push_word(input logic cmd, input int s);
        word_t w;
        w.command = cmd;
        w.sample = sample_t'(s);
        pending_words.push_back(w);
    endtask

    // Random words: mostly audio of varied level, some retriggers.
    task automatic push_random(input int n);
        int r, amp;
        for (int i = 0; i < n; i++)
        begin
            r = $urandom_range(0, 39);
            amp = $urandom_range(1, 32767);
            if (r == 0)
                push_word(CMD_RESTART, $urandom);
            else if (r < 16)
                push_word(CMD_SAMPLE, $urandom);
            else if (r < 28)
                push_word(CMD_SAMPLE, $signed($urandom_range(0, 2 * amp)) - amp);
            else if (r < 37)
                push_word(CMD_SAMPLE, $signed($urandom_range(0, 400)) - 200);
            else
                push_word(CMD_SAMPLE, ($urandom_range(0, 1) != 0) ? 32767 : -32768);
        end
    endtask

    // Stimulus and end of run.
    initial
    begin
        error_count = 0;
        idle_cycles = 0;
        send_gap = 0;
        recv_stall = 0;
        no_idling = 1'b0;
        target_lvl = 4915;
        max_gain = 6144;
        clip_lvl = 13107;
        emph_weight = 0;
        bw_sel = 3;
        rate_sel = 0;
        clear_chain();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Directed words at reset configuration.
        push_word(CMD_SAMPLE, 32767);
        push_word(CMD_SAMPLE, -32768);
        push_word(CMD_SAMPLE, 0);
        push_word(CMD_SAMPLE, -1);
        push_word(CMD_SAMPLE, 1);
        push_word(CMD_SAMPLE, 16'h5555);
        push_word(CMD_SAMPLE, 16'hAAAA);
        for (int i = 0; i < 8; i++)
            push_word(CMD_SAMPLE, (i % 2 == 0) ? 32767 : -32768);
        push_word(CMD_RESTART, 0);
        push_word(CMD_SAMPLE, 30000);
        push_word(CMD_RESTART, -1);
        push_word(CMD_RESTART, 0);
        push_word(CMD_SAMPLE, -30000);
        push_word(CMD_SAMPLE, 0);
        wait_drained();

        // Phases at varied settings; the first ones hit the register extremes.
        for (int p = 0; p < 10; p++)
        begin
            case (p)
                0:
                begin
                    write_reg(REG_AGC_TARGET, 32767);
                    write_reg(REG_AGC_MAX_GAIN, 65535);
                    write_reg(REG_CLIP_LEVEL, 32767);
                    write_reg(REG_PREEMPHASIS, 32767);
                    write_reg(REG_BANDWIDTH, 4);
                    write_reg(REG_RATE, 1);
                end
                1:
                begin
                    write_reg(REG_AGC_TARGET, 0);
                    write_reg(REG_AGC_MAX_GAIN, 410);
                    write_reg(REG_CLIP_LEVEL, 1);
                    write_reg(REG_PREEMPHASIS, 0);
                    write_reg(REG_BANDWIDTH, 0);
                    write_reg(REG_RATE, 0);
                end
                default:
                begin
                    write_reg(REG_AGC_TARGET, $urandom_range(0, 32767));
                    write_reg(REG_AGC_MAX_GAIN, $urandom_range(410, 65535));
                    write_reg(REG_CLIP_LEVEL, $urandom_range(1, 32767));
                    write_reg(REG_PREEMPHASIS,
                              ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 32767));
                    write_reg(REG_BANDWIDTH, $urandom_range(0, 4));
                    write_reg(REG_RATE, $urandom_range(0, 1));
                end
            endcase
            no_idling = (p % 3 == 2);
            push_random(60);
            // Sender holds until every result of the first half is back.
            wait_drained();
            push_random(53);
            wait_drained();
        end

        if (error_count == 0)
            $display("speech_compressor_chain_unit_tb OK");
        else
            $display("speech_compressor_chain_unit_tb NOT OK");
        $finish;
    end

endmodule

>>> speech_compressor_chain_unit.f
design/scc_pkg.sv
design/scc_if.sv
design/speech_compressor_chain_unit.sv
design/scc_checker.sv
sim/speech_compressor_chain_unit_tb.sv
